// File: hdl/hpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared types, constants and helpers of the capped handle pool allocator.
// ----------------------------------------------------------------------------
package hpa_pkg;

	localparam int POOL_SLOTS = 64;
	localparam int HANDLE_W   = 6;
	localparam int COUNT_W    = 7;

	localparam logic [COUNT_W-1:0] INIT_COUNT_RST = 7'd4;
	localparam logic [COUNT_W-1:0] MAX_IN_USE_RST = 7'd6;

	typedef enum logic [1:0] {
		STAT_GRANTED   = 2'd0,
		STAT_EXHAUSTED = 2'd1,
		STAT_RELEASED  = 2'd2,
		STAT_IGNORED   = 2'd3
	} status_t;

	typedef enum logic {
		KIND_ACQUIRE = 1'b0,
		KIND_RELEASE = 1'b1
	} kind_t;

	typedef enum logic {
		REG_INITIAL_COUNT = 1'b0,
		REG_MAX_IN_USE    = 1'b1
	} reg_idx_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Preload depth saturates at the pool size.
	function automatic logic [COUNT_W-1:0] preload_count(input logic [COUNT_W-1:0] v);
		logic [COUNT_W-1:0] lim;
		lim = COUNT_W'(POOL_SLOTS);
		return (v > lim) ? lim : v;
	endfunction

endpackage

// File: hdl/hpa_stack_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_stack_mem
// Free stack storage: synchronous RAM with a registered read. A per-entry
// written bit stands in for the preload: an unwritten entry reads as its index.
// ----------------------------------------------------------------------------
module hpa_stack_mem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clear,
	input  logic                         rd_en,
	input  logic [hpa_pkg::HANDLE_W-1:0] rd_addr,
	output logic [hpa_pkg::HANDLE_W-1:0] rd_data,
	input  logic                         wr_en,
	input  logic [hpa_pkg::HANDLE_W-1:0] wr_addr,
	input  logic [hpa_pkg::HANDLE_W-1:0] wr_data
);

	logic [hpa_pkg::HANDLE_W-1:0] mem [hpa_pkg::POOL_SLOTS];
	logic [hpa_pkg::POOL_SLOTS-1:0] written_q;

	logic [hpa_pkg::HANDLE_W-1:0] data_s1;
	logic [hpa_pkg::HANDLE_W-1:0] addr_s1;
	logic                         written_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_s1    <= mem[rd_addr];
			addr_s1    <= rd_addr;
			written_s1 <= written_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (clear) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = written_s1 ? data_s1 : addr_s1;

endmodule

// File: hdl/capped_handle_pool_allocator.sv
`timescale 1ns / 1ps
// Done: the accepting edge moves the sequencer to S_EXEC; done is registered
//   from S_EXEC. A new item is accepted only while idle: busy is high in S_EXEC,
//   where the update and write-back follow the stack read of the top entry.
// Reset: handles 0..3 sit on the free stack, limit 6; the preload is immediate
//   (per-entry written bits), no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
// capped_handle_pool_allocator
// Hands out and takes back numbered handles from a LIFO free stack with
// in-use marks, a creation count and an in-use cap on creating new handles.
// ----------------------------------------------------------------------------
module capped_handle_pool_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         kind,
	input  logic [hpa_pkg::HANDLE_W-1:0] handle,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [hpa_pkg::COUNT_W-1:0]  cfg_wdata,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [hpa_pkg::HANDLE_W-1:0] granted_handle,
	output logic [hpa_pkg::COUNT_W-1:0]  in_use_count,
	output logic [hpa_pkg::COUNT_W-1:0]  free_count
);

	localparam int CW = hpa_pkg::COUNT_W;
	localparam int HW = hpa_pkg::HANDLE_W;

	hpa_pkg::state_t state_q, state_d;

	logic [CW-1:0] max_in_use_q;
	logic [CW-1:0] depth_q, depth_d;
	logic [CW-1:0] used_q, used_d;
	logic [CW-1:0] created_q, created_d;

	logic                           mark_mem [hpa_pkg::POOL_SLOTS];
	logic [hpa_pkg::POOL_SLOTS-1:0] mark_vld_q;
	logic                           mark_data_s1;
	logic                           mark_vld_s1;
	logic                           mark_hit;
	logic                           mark_wr;

	hpa_pkg::kind_t kind_s1;
	logic [HW-1:0]  handle_s1;

	logic accept;
	logic exec;
	logic init_wr;

	logic [HW-1:0] top_data;
	logic          mem_wr;
	logic [HW-1:0] mem_wr_addr;

	hpa_pkg::status_t stat_d;
	logic [HW-1:0]    grant_d;
	logic             mark_set;
	logic             mark_clr;
	logic [HW-1:0]    mark_idx;

	hpa_pkg::status_t status_q;
	logic [HW-1:0]    granted_q;
	logic [CW-1:0]    in_use_q;
	logic [CW-1:0]    free_q;
	logic             done_q;

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hpa_pkg::S_IDLE: if (start) state_d = hpa_pkg::S_EXEC;
			hpa_pkg::S_EXEC: state_d = hpa_pkg::S_IDLE;
			default:         state_d = hpa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b0;
		exec = 1'b0;
		unique case (state_q)
			hpa_pkg::S_IDLE: begin
				busy = 1'b0;
				exec = 1'b0;
			end
			hpa_pkg::S_EXEC: begin
				busy = 1'b1;
				exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
				exec = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hpa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign accept  = start && !busy;
	assign init_wr = cfg_we && (cfg_index == hpa_pkg::REG_INITIAL_COUNT);

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= hpa_pkg::kind_t'(kind);
			handle_s1 <= handle;
		end
	end

	// ---------------- stack memory ----------------
	hpa_stack_mem u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (init_wr),
		.rd_en   (accept),
		.rd_addr (HW'(depth_q - CW'(1))),
		.rd_data (top_data),
		.wr_en   (mem_wr),
		.wr_addr (mem_wr_addr),
		.wr_data (handle_s1)
	);

	// ---------------- in-use mark memory ----------------
	// read at the released handle on accept; an unwritten entry reads as clear
	always_ff @(posedge clk) begin
		if (mark_wr) begin
			mark_mem[mark_idx] <= mark_set;
		end
		if (accept) begin
			mark_data_s1 <= mark_mem[handle];
			mark_vld_s1  <= mark_vld_q[handle];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_vld_q <= '0;
		end else if (init_wr) begin
			mark_vld_q <= '0;
		end else if (mark_wr) begin
			mark_vld_q[mark_idx] <= 1'b1;
		end
	end

	assign mark_hit = mark_vld_s1 && mark_data_s1;
	assign mark_wr  = exec && (mark_set || mark_clr);

	// ---------------- item update ----------------
	always_comb begin
		depth_d     = depth_q;
		used_d      = used_q;
		created_d   = created_q;
		stat_d      = hpa_pkg::STAT_IGNORED;
		grant_d     = '0;
		mark_set    = 1'b0;
		mark_clr    = 1'b0;
		mark_idx    = handle_s1;
		mem_wr      = 1'b0;
		mem_wr_addr = depth_q[HW-1:0];
		case (kind_s1)
			hpa_pkg::KIND_ACQUIRE: begin
				if (depth_q != '0) begin
					depth_d  = depth_q - CW'(1);
					grant_d  = top_data;
					mark_set = 1'b1;
					mark_idx = top_data;
					used_d   = used_q + CW'(1);
					stat_d   = hpa_pkg::STAT_GRANTED;
				end else if (used_q < max_in_use_q &&
				             created_q < CW'(hpa_pkg::POOL_SLOTS)) begin
					grant_d   = created_q[HW-1:0];
					created_d = created_q + CW'(1);
					mark_set  = 1'b1;
					mark_idx  = created_q[HW-1:0];
					used_d    = used_q + CW'(1);
					stat_d    = hpa_pkg::STAT_GRANTED;
				end else begin
					stat_d = hpa_pkg::STAT_EXHAUSTED;
				end
			end
			default: begin
				if (mark_hit && depth_q < CW'(hpa_pkg::POOL_SLOTS)) begin
					mark_clr = 1'b1;
					if (used_q != '0) used_d = used_q - CW'(1);
					mem_wr  = exec;
					depth_d = depth_q + CW'(1);
					stat_d  = hpa_pkg::STAT_RELEASED;
				end else begin
					stat_d = hpa_pkg::STAT_IGNORED;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_in_use_q <= hpa_pkg::MAX_IN_USE_RST;
			depth_q      <= hpa_pkg::preload_count(hpa_pkg::INIT_COUNT_RST);
			created_q    <= hpa_pkg::preload_count(hpa_pkg::INIT_COUNT_RST);
			used_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= exec;
			if (cfg_we) begin
				unique case (hpa_pkg::reg_idx_t'(cfg_index))
					hpa_pkg::REG_INITIAL_COUNT: begin
						depth_q   <= hpa_pkg::preload_count(cfg_wdata);
						created_q <= hpa_pkg::preload_count(cfg_wdata);
						used_q    <= '0;
					end
					hpa_pkg::REG_MAX_IN_USE: max_in_use_q <= cfg_wdata;
					default: ;
				endcase
			end else if (exec) begin
				depth_q   <= depth_d;
				used_q    <= used_d;
				created_q <= created_d;
			end
		end
	end

	// result beat registers
	always_ff @(posedge clk) begin
		if (exec) begin
			status_q  <= stat_d;
			granted_q <= grant_d;
			in_use_q  <= used_d;
			free_q    <= depth_d;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign granted_handle = granted_q;
	assign in_use_count   = in_use_q;
	assign free_count     = free_q;

	// ---------------- checks ----------------
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == hpa_pkg::S_EXEC))
		else $error("result beat without an executed item");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while an item is executing");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= CW'(hpa_pkg::POOL_SLOTS) && created_q <= CW'(hpa_pkg::POOL_SLOTS))
		else $error("stack depth or created count beyond pool size");

	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != hpa_pkg::STAT_GRANTED) |-> granted_handle == '0)
		else $error("nonzero handle on a non-grant beat");

	a_release_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == hpa_pkg::STAT_RELEASED) |-> $past(mem_wr))
		else $error("release reported without a stack push");

endmodule

// File: bench/pool_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_checker
// Watches the command, result and register ports of the handle pool
// allocator. It keeps its own copy of the free stack, in-use marks and
// counters, works out the expected outcome of every accepted beat and
// compares each result strobe with the oldest pending outcome.
// ----------------------------------------------------------------------------
module pool_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic                         kind,
	input  logic [hpa_pkg::HANDLE_W-1:0] handle,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [hpa_pkg::COUNT_W-1:0]  cfg_wdata,
	input  logic                         done,
	input  logic [1:0]                   status,
	input  logic [hpa_pkg::HANDLE_W-1:0] granted_handle,
	input  logic [hpa_pkg::COUNT_W-1:0]  in_use_count,
	input  logic [hpa_pkg::COUNT_W-1:0]  free_count,
	output int                           errors,
	output int                           outstanding
);

	localparam int HW    = hpa_pkg::HANDLE_W;
	localparam int CW    = hpa_pkg::COUNT_W;
	localparam int SLOTS = hpa_pkg::POOL_SLOTS;
	localparam int RING  = 8;

	typedef struct packed {
		logic [1:0]    st;
		logic [HW-1:0] gh;
		logic [CW-1:0] in_use;
		logic [CW-1:0] on_stack;
	} pool_outcome_t;

	logic [HW-1:0] free_lifo [SLOTS];
	logic          taken     [SLOTS];
	logic [CW-1:0] lifo_depth;
	logic [CW-1:0] taken_total;
	logic [CW-1:0] made_total;
	logic [CW-1:0] preload_reg;
	logic [CW-1:0] cap_reg;
	pool_outcome_t pending [RING];
	int            wr_cnt;
	int            rd_cnt;
	int            bad_total;

	// Rebuild the pool from preload_reg; depth saturates at the pool size.
	function automatic void restock_pool();
		int n;
		n = (preload_reg > CW'(SLOTS)) ? SLOTS : int'(preload_reg);
		for (int i = 0; i < SLOTS; i++) begin
			free_lifo[i] = (i < n) ? HW'(i) : '0;
			taken[i]     = 1'b0;
		end
		lifo_depth  = CW'(n);
		taken_total = '0;
		made_total  = CW'(n);
	endfunction

	function automatic pool_outcome_t pool_outcome(input hpa_pkg::kind_t k,
			input logic [HW-1:0] h);
		pool_outcome_t r;
		r.st = hpa_pkg::STAT_IGNORED;
		r.gh = '0;
		if (k == hpa_pkg::KIND_ACQUIRE) begin
			if (lifo_depth != '0) begin
				// a stacked handle is handed out even at or over the cap
				lifo_depth   = lifo_depth - CW'(1);
				r.gh         = free_lifo[lifo_depth[HW-1:0]];
				taken[r.gh]  = 1'b1;
				taken_total  = taken_total + CW'(1);
				r.st         = hpa_pkg::STAT_GRANTED;
			end else if (taken_total < cap_reg && made_total < CW'(SLOTS)) begin
				r.gh         = made_total[HW-1:0];
				made_total   = made_total + CW'(1);
				taken[r.gh]  = 1'b1;
				taken_total  = taken_total + CW'(1);
				r.st         = hpa_pkg::STAT_GRANTED;
			end else begin
				r.st = hpa_pkg::STAT_EXHAUSTED;
			end
		end else begin
			// a 6-bit handle is always inside the 64-slot pool
			if (taken[h] && lifo_depth < CW'(SLOTS)) begin
				taken[h] = 1'b0;
				if (taken_total != '0)
					taken_total = taken_total - CW'(1);
				free_lifo[lifo_depth[HW-1:0]] = h;
				lifo_depth = lifo_depth + CW'(1);
				r.st       = hpa_pkg::STAT_RELEASED;
			end else begin
				r.st = hpa_pkg::STAT_IGNORED;
			end
		end
		r.in_use   = taken_total;
		r.on_stack = lifo_depth;
		return r;
	endfunction

	task automatic flag(input string what, input logic [7:0] exp_v, input logic [7:0] act_v);
		bad_total++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pool_outcome_t want;
		if (!arst_n) begin
			preload_reg = hpa_pkg::INIT_COUNT_RST;
			cap_reg     = hpa_pkg::MAX_IN_USE_RST;
			restock_pool();
			wr_cnt      = 0;
			rd_cnt      = 0;
			bad_total   = 0;
			errors      <= 0;
			outstanding <= 0;
		end else begin
			// results belong to older beats, so retire before queuing a new one
			if (done) begin
				if (wr_cnt == rd_cnt) begin
					bad_total++;
					$display("%0t: result with no beat pending, status %0d handle %0d",
						$time, status, granted_handle);
				end else begin
					want = pending[rd_cnt % RING];
					rd_cnt++;
					if (status !== want.st)
						flag("status", want.st, status);
					if (granted_handle !== want.gh)
						flag("granted_handle", want.gh, granted_handle);
					if (in_use_count !== want.in_use)
						flag("in_use_count", want.in_use, in_use_count);
					if (free_count !== want.on_stack)
						flag("free_count", want.on_stack, free_count);
				end
			end
			if (cfg_we) begin
				if (cfg_index == hpa_pkg::REG_INITIAL_COUNT) begin
					preload_reg = cfg_wdata;
					restock_pool();
				end else begin
					cap_reg = cfg_wdata;
				end
			end
			if (start && !busy) begin
				if (wr_cnt - rd_cnt >= RING) begin
					bad_total++;
					$display("%0t: more than %0d beats pending", $time, RING);
				end else begin
					pending[wr_cnt % RING] = pool_outcome(hpa_pkg::kind_t'(kind), handle);
					wr_cnt++;
				end
			end
			errors      <= bad_total;
			outstanding <= wr_cnt - rd_cnt;
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the capped handle pool allocator. A short directed
// run hits the stack, creation, cap and release corner cases, then random
// phases sweep pool settings and sender idling while pool_checker predicts.
// ----------------------------------------------------------------------------
module tb;

	localparam int HW             = hpa_pkg::HANDLE_W;
	localparam int CW             = hpa_pkg::COUNT_W;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_PHASES       = 9;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          start     = 1'b0;
	logic          kind      = 1'b0;
	logic [HW-1:0] handle    = '0;
	logic          cfg_we    = 1'b0;
	logic          cfg_index = 1'b0;
	logic [CW-1:0] cfg_wdata = '0;
	logic          busy;
	logic          done;
	logic [1:0]    status;
	logic [HW-1:0] granted_handle;
	logic [CW-1:0] in_use_count;
	logic [CW-1:0] free_count;
	int            errors;
	int            outstanding;
	int            idle_pct     = 0;
	int            quiet_cycles = 0;

	// per phase: preload, cap, percent of acquires, number of beats
	int ph_init [N_PHASES] = '{4, 0, 64, 1, 8, 127, 0, 16, 2};
	int ph_cap  [N_PHASES] = '{6, 0, 127, 64, 3, 20, 64, 16, 5};
	int ph_acq  [N_PHASES] = '{55, 50, 75, 65, 50, 45, 85, 50, 50};
	int ph_len  [N_PHASES] = '{90, 60, 150, 100, 90, 90, 160, 90, 90};

	capped_handle_pool_allocator uut (.*);

	pool_checker chk (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// start stays high across back-to-back beats; it is only lowered for a gap
	task automatic send_beat(input hpa_pkg::kind_t k, input logic [HW-1:0] h);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start  <= 1'b1;
		kind   <= k;
		handle <= h;
		do @(posedge clk); while (busy);
	endtask

	// outstanding is registered behind the checker's counters, hence the first wait
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic setup_pool(input logic [CW-1:0] init_v, input logic [CW-1:0] cap_v);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= hpa_pkg::REG_MAX_IN_USE;
		cfg_wdata <= cap_v;
		@(posedge clk);
		cfg_index <= hpa_pkg::REG_INITIAL_COUNT;
		cfg_wdata <= init_v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int span;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pool: pop 3..0, create 4 and 5, then the cap is hit
		repeat (6) send_beat(hpa_pkg::KIND_ACQUIRE, HW'($urandom));
		send_beat(hpa_pkg::KIND_ACQUIRE, 6'd63);
		send_beat(hpa_pkg::KIND_RELEASE, 6'd63);
		send_beat(hpa_pkg::KIND_RELEASE, 6'd5);
		send_beat(hpa_pkg::KIND_RELEASE, 6'd5);
		send_beat(hpa_pkg::KIND_ACQUIRE, 6'd0);

		// oversized preload saturates; stacked handle granted with a zero cap
		setup_pool(7'd127, 7'd0);
		send_beat(hpa_pkg::KIND_ACQUIRE, 6'd0);
		send_beat(hpa_pkg::KIND_RELEASE, 6'd63);
		send_beat(hpa_pkg::KIND_RELEASE, 6'd0);

		// empty pool with zero cap
		setup_pool(7'd0, 7'd0);
		send_beat(hpa_pkg::KIND_ACQUIRE, 6'd63);
		send_beat(hpa_pkg::KIND_RELEASE, 6'd0);

		for (int p = 0; p < N_PHASES; p++) begin
			setup_pool(CW'(ph_init[p]), CW'(ph_cap[p]));
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 68;
				default: idle_pct = 24;
			endcase
			// aim releases at handles that can plausibly be out
			span = (ph_init[p] > 64) ? 64 : ph_init[p];
			if (ph_cap[p] > span)
				span = ph_cap[p];
			span = (span + 2 > 63) ? 63 : span + 2;
			for (int i = 0; i < ph_len[p]; i++) begin
				if ($urandom_range(0, 99) < ph_acq[p])
					send_beat(hpa_pkg::KIND_ACQUIRE, HW'($urandom));
				else if ($urandom_range(0, 6) == 0)
					send_beat(hpa_pkg::KIND_RELEASE, HW'($urandom));
				else
					send_beat(hpa_pkg::KIND_RELEASE, HW'($urandom_range(0, span)));
				if ($urandom_range(0, 59) == 0)
					drain();
			end
		end

		drain();
		if (errors == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
